/* hdl/ecr_pkg.sv */
// ----------------------------------------------------------------------------
// ecr_pkg
// Types and constants shared by the edge coverage recorder modules.
// ----------------------------------------------------------------------------
package ecr_pkg;

  localparam int unsigned LIMIT_W   = 12;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned FILL_W    = 13;
  localparam int unsigned APB_AW    = 2;
  localparam int unsigned APB_DW    = 32;
  // highest edge id the limit register can express, plus one
  localparam int unsigned ID_SPAN   = 4096;

  localparam logic [CNT_W-1:0]  SAT_COUNT       = 8'd128;
  localparam logic [APB_AW-1:0] ADDR_EDGE_LIMIT = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 12'd4095;

  typedef enum logic [1:0] {
    ACT_HIT       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_READ_CNT  = 2'd2,
    ACT_READ_LIST = 2'd3
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [ID_W-1:0]    edge_id;
    logic [IDX_W-1:0]   list_index;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]   hit_count;
    logic               first_hit;
    logic               in_range;
    logic [FILL_W-1:0]  list_length;
    logic [LIMIT_W-1:0] listed_edge;
  } res_t;

  // classified item as it sits in the queue
  typedef struct packed {
    action_e            action;
    logic               id_ok;
    logic [LIMIT_W-1:0] edge_num;
    logic [IDX_W-1:0]   list_index;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_INIT = 3'd0,
    ST_IDLE = 3'd1,
    ST_HIT  = 3'd2,
    ST_CNT  = 3'd3,
    ST_LIST = 3'd4,
    ST_CLR  = 3'd5
  } back_state_e;

endpackage

/* hdl/edge_coverage_recorder.sv */
// ----------------------------------------------------------------------------
// edge_coverage_recorder
// Saturating per-edge hit counter with a first-hit list and list-walk clear.
// ----------------------------------------------------------------------------
// a hit, count read or list read passes through the queue, a registered
//   memory read and a registered result; out-of-range ids and list reads
//   past the end skip the memory read; commands queue while one runs
// a hit reads the count memory, then writes it; a clear walks the first-hit
//   list at one entry a cycle; after reset the count memory is zeroed one
//   entry a cycle with busy high, and the limit register resets to 4095
module edge_coverage_recorder #(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ecr_pkg::cmd_t               cmd_i,
  output logic                        done_o,
  output ecr_pkg::res_t               res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ecr_pkg::APB_AW-1:0]  paddr,
  input  logic [ecr_pkg::APB_DW-1:0]  pwdata,
  output logic [ecr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ecr_pkg::*;

  logic [LIMIT_W-1:0] edge_limit_q;
  queue_out_t         q_out;
  back_stat_t         back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      edge_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_EDGE_LIMIT) ? APB_DW'(edge_limit_q) : '0;

  ecr_front #(.MAX_EDGES(MAX_EDGES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_i        (cmd_i),
    .edge_limit_i (edge_limit_q),
    .stat_i       (back_stat),
    .busy_o       (busy),
    .q_o          (q_out)
  );

  ecr_back #(.MAX_EDGES(MAX_EDGES)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_out),
    .stat_o (back_stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

/* hdl/ecr_ram.sv */
// ----------------------------------------------------------------------------
// ecr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ecr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ecr_front.sv */
// ----------------------------------------------------------------------------
// ecr_front
// Accepts commands, checks edge ids against the limit and queues them.
// ----------------------------------------------------------------------------
module ecr_front #(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  ecr_pkg::cmd_t              cmd_i,
  input  logic [ecr_pkg::LIMIT_W-1:0] edge_limit_i,
  input  ecr_pkg::back_stat_t        stat_i,
  output logic                       busy_o,
  output ecr_pkg::queue_out_t        q_o
);
  import ecr_pkg::*;

  localparam int unsigned DEPTH = (MAX_EDGES > ID_SPAN) ? ID_SPAN : MAX_EDGES;
  localparam logic [LIMIT_W-1:0] TOP_ID = LIMIT_W'(DEPTH - 1);

  item_t              slot_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic [LIMIT_W-1:0] eff_limit;
  item_t              item_in;
  logic               push, pop;

  // limit clamped to the store
  assign eff_limit = (edge_limit_i > TOP_ID) ? TOP_ID : edge_limit_i;

  always_comb begin
    item_in.action     = cmd_i.action;
    item_in.id_ok      = (cmd_i.edge_id != '0) &&
                         (cmd_i.edge_id <= {{(ID_W-LIMIT_W){1'b0}}, eff_limit});
    item_in.edge_num   = cmd_i.edge_id[LIMIT_W-1:0];
    item_in.list_index = cmd_i.list_index;
  end

  assign busy_o = (cnt_q == 2'd2) || stat_i.init_busy;
  assign push   = start_i && !busy_o;
  assign pop    = stat_i.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.item  = slot_q[rd_ptr_q];

endmodule

/* hdl/ecr_back.sv */
// ----------------------------------------------------------------------------
// ecr_back
// Executes queued items against the count and first-hit memories.
// ----------------------------------------------------------------------------
module ecr_back #(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecr_pkg::queue_out_t q_i,
  output ecr_pkg::back_stat_t stat_o,
  output logic                done_o,
  output ecr_pkg::res_t       res_o
);
  import ecr_pkg::*;

  localparam int unsigned DEPTH = (MAX_EDGES > ID_SPAN) ? ID_SPAN : MAX_EDGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  back_state_e        state_q, state_d;
  item_t              cur_q, cur_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  clr_idx_q, clr_idx_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      init_addr_q, init_addr_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;
  logic               pop;

  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               lst_we;
  logic [AW-1:0]      lst_waddr, lst_raddr;
  logic [LIMIT_W-1:0] lst_wdata, lst_rdata;

  logic               list_hit;
  logic               clr_more;

  assign list_hit = {1'b0, q_i.item.list_index} < fill_q;
  assign clr_more = clr_idx_q < fill_q;

  ecr_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  ecr_ram #(.WIDTH(LIMIT_W), .DEPTH(DEPTH)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          case (q_i.item.action)
            ACT_HIT:       state_d = q_i.item.id_ok ? ST_HIT : ST_IDLE;
            ACT_READ_CNT:  state_d = q_i.item.id_ok ? ST_CNT : ST_IDLE;
            ACT_READ_LIST: state_d = list_hit ? ST_LIST : ST_IDLE;
            ACT_CLEAR:     state_d = ST_CLR;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_HIT, ST_CNT, ST_LIST: state_d = ST_IDLE;
      ST_CLR: begin
        if (!clr_more) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_we      = 1'b0;
    cnt_waddr   = cur_q.edge_num[AW-1:0];
    cnt_wdata   = '0;
    cnt_raddr   = q_i.item.edge_num[AW-1:0];
    lst_we      = 1'b0;
    lst_waddr   = fill_q[AW-1:0];
    lst_wdata   = cur_q.edge_num;
    lst_raddr   = q_i.item.list_index[AW-1:0];
    pop         = 1'b0;
    cur_d       = cur_q;
    fill_d      = fill_q;
    clr_idx_d   = clr_idx_q;
    pend_d      = 1'b0;
    init_addr_d = init_addr_q;
    done_d      = 1'b0;
    res_d       = '0;
    res_d.list_length = fill_q;
    case (state_q)
      ST_INIT: begin
        cnt_we      = 1'b1;
        cnt_waddr   = init_addr_q;
        init_addr_d = init_addr_q + AW'(1);
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          pop   = 1'b1;
          cur_d = q_i.item;
          case (q_i.item.action)
            ACT_HIT:       done_d = !q_i.item.id_ok;
            ACT_READ_CNT:  done_d = !q_i.item.id_ok;
            ACT_READ_LIST: done_d = !list_hit;
            ACT_CLEAR:     clr_idx_d = '0;
            default:       done_d = 1'b0;
          endcase
        end
      end
      ST_HIT: begin
        cnt_we          = 1'b1;
        res_d.in_range  = 1'b1;
        done_d          = 1'b1;
        if (cnt_rdata == '0) begin
          cnt_wdata       = CNT_W'(1);
          lst_we          = 1'b1;
          fill_d          = fill_q + FILL_W'(1);
          res_d.first_hit = 1'b1;
        end else if (cnt_rdata < SAT_COUNT) begin
          cnt_wdata = cnt_rdata + CNT_W'(1);
        end else begin
          cnt_wdata = cnt_rdata;
        end
        res_d.hit_count   = cnt_wdata;
        res_d.list_length = fill_d;
      end
      ST_CNT: begin
        res_d.hit_count = cnt_rdata;
        res_d.in_range  = 1'b1;
        done_d          = 1'b1;
      end
      ST_LIST: begin
        res_d.listed_edge = lst_rdata;
        done_d            = 1'b1;
      end
      ST_CLR: begin
        // list read in the cycle before its count zeroing write
        lst_raddr = clr_idx_q[AW-1:0];
        cnt_we    = pend_q;
        cnt_waddr = lst_rdata[AW-1:0];
        if (clr_more) begin
          clr_idx_d = clr_idx_q + FILL_W'(1);
          pend_d    = 1'b1;
        end else begin
          fill_d            = '0;
          res_d.list_length = '0;
          done_d            = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fill_q      <= '0;
      clr_idx_q   <= '0;
      pend_q      <= 1'b0;
      init_addr_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      clr_idx_q   <= clr_idx_d;
      pend_q      <= pend_d;
      init_addr_q <= init_addr_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign stat_o.init_busy = (state_q == ST_INIT);
  assign stat_o.pop       = pop;
  assign done_o           = done_q;
  assign res_o            = res_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(DEPTH))
    else $error("first-hit list grew past the store");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) != ST_INIT)
    else $error("result during the clearing pass");

  a_append_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lst_we |-> (cnt_rdata == '0) && (state_q == ST_HIT))
    else $error("list append for an edge already counted");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && $past(state_q) == ST_CLR) |-> (fill_q == '0) && (res_q.list_length == '0))
    else $error("clear left entries in the list");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we && state_q == ST_HIT) |-> (cnt_wdata != '0) && (cnt_wdata <= SAT_COUNT))
    else $error("count left the saturating range");
`endif

endmodule

/* tb/coverage_record_checker.sv */
// ----------------------------------------------------------------------------
// coverage_record_checker
// Watches the command, result and register ports of the edge coverage
// recorder, keeps its own copy of the per-edge tallies and the first-hit
// list, and compares every result and every register read with it.
// ----------------------------------------------------------------------------
module coverage_record_checker #(
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  ecr_pkg::cmd_t              cmd_i,
  input  logic                       done_o,
  input  ecr_pkg::res_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ecr_pkg::APB_AW-1:0] paddr,
  input  logic [ecr_pkg::APB_DW-1:0] pwdata,
  input  logic [ecr_pkg::APB_DW-1:0] prdata,
  input  logic                       pready,
  output int unsigned                mismatches,
  output int unsigned                pending,
  output int unsigned                checked,
  output int unsigned                saturated
);

  timeunit 1ns;
  timeprecision 1ps;

  import ecr_pkg::*;

  logic [CNT_W-1:0]   edge_tally [MAX_EDGES];
  logic [ID_W-1:0]    first_seen [MAX_EDGES];
  int unsigned        seen_fill;
  logic [LIMIT_W-1:0] limit_reg;
  res_t               expected_results[$];

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // applies one command to the tallies and the list, returns its result
  function automatic res_t apply_coverage_cmd(input cmd_t c);
    res_t        r;
    int unsigned top_id;
    int unsigned id;
    bit          valid;
    logic [CNT_W-1:0] seen;
    r      = '0;
    id     = c.edge_id;
    top_id = (limit_reg > MAX_EDGES - 1) ? MAX_EDGES - 1 : limit_reg;
    valid  = (id >= 1) && (id <= top_id);
    case (c.action)
      ACT_HIT: begin
        if (valid) begin
          seen = edge_tally[id];
          r.in_range = 1'b1;
          if (seen == '0) begin
            if (seen_fill < MAX_EDGES) begin
              first_seen[seen_fill] = c.edge_id;
              seen_fill++;
            end
            edge_tally[id] = CNT_W'(1);
            r.first_hit = 1'b1;
          end else if (seen < SAT_COUNT) begin
            edge_tally[id] = seen + 1'b1;
          end
          r.hit_count = edge_tally[id];
        end
      end
      ACT_CLEAR: begin
        // only listed edges are zeroed
        for (int unsigned k = 0; k < seen_fill; k++) begin
          if (first_seen[k] < MAX_EDGES) edge_tally[first_seen[k]] = '0;
        end
        seen_fill = 0;
      end
      ACT_READ_CNT: begin
        if (valid) begin
          r.in_range  = 1'b1;
          r.hit_count = edge_tally[id];
        end
      end
      default: begin
        if (c.list_index < seen_fill) begin
          r.listed_edge = first_seen[c.list_index][LIMIT_W-1:0];
        end
      end
    endcase
    r.list_length = FILL_W'(seen_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < MAX_EDGES; k++) begin
        edge_tally[k] = '0;
        first_seen[k] = '0;
      end
      seen_fill  = 0;
      limit_reg  = LIMIT_RESET;
      expected_results.delete();
      pending    = 0;
      mismatches = 0;
      checked    = 0;
      saturated  = 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_EDGE_LIMIT) begin
        if (pwrite) begin
          limit_reg = pwdata[LIMIT_W-1:0];
        end else begin
          check_field("edge_limit readback", limit_reg, prdata);
        end
      end
      // a result always leaves after its command is taken, so check first
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit_count", want.hit_count, res_o.hit_count);
          check_field("first_hit", want.first_hit, res_o.first_hit);
          check_field("in_range", want.in_range, res_o.in_range);
          check_field("list_length", want.list_length, res_o.list_length);
          check_field("listed_edge", want.listed_edge, res_o.listed_edge);
          checked++;
          if (want.hit_count == SAT_COUNT) saturated++;
        end
      end
      if (start && !busy) expected_results.push_back(apply_coverage_cmd(cmd_i));
      pending = expected_results.size();
    end
  end

endmodule

/* tb/edge_coverage_recorder_test.sv */
// ----------------------------------------------------------------------------
// edge_coverage_recorder_test
// Drives the edge coverage recorder with directed corner commands and then
// random phases under several edge limits, with random gaps between
// commands; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module edge_coverage_recorder_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ecr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  cmd_t              cmd     = '0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic              busy;
  logic              done_o;
  res_t              res_o;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned mismatches, pending, checked, saturated;
  int unsigned commands_sent = 0;
  int unsigned limit_writes  = 0;
  bit          quiet         = 1'b0;

  edge_coverage_recorder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  coverage_record_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .done_o     (done_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .saturated  (saturated)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(99) >= 35) return 0;
    return $urandom_range(1, 4);
  endfunction

  function automatic cmd_t make_cmd(input action_e act, input int unsigned id,
                                    input int unsigned idx);
    cmd_t c;
    c.action     = act;
    c.edge_id    = ID_W'(id);
    c.list_index = IDX_W'(idx);
    return c;
  endfunction

  // start stays high across back-to-back transactions
  task automatic issue(input cmd_t c);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    commands_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_EDGE_LIMIT;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input int unsigned lim);
    wait_idle();
    apb_access(1'b1, APB_DW'(lim));
    apb_access(1'b0, '0);
    limit_writes++;
  endtask

  function automatic int unsigned pick_id(input int unsigned top_id,
                                          input int unsigned pool,
                                          input int unsigned hot_pct);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    if (top_id != 0 && roll < hot_pct) return top_id;
    if (top_id != 0 && roll < 88) begin
      span = (pool == 0 || pool > top_id) ? top_id : pool;
      return $urandom_range(1, span);
    end
    case ($urandom_range(3))
      0:       return 0;
      1:       return (top_id + 1) & 16'hFFFF;
      2:       return 16'hFFFF;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  function automatic cmd_t random_cmd(input int unsigned top_id, input int unsigned pool,
                                      input int unsigned hot_pct,
                                      input int unsigned clear_pct);
    cmd_t        c;
    int unsigned roll;
    // fields an action ignores still carry random bits
    c.edge_id    = ID_W'($urandom_range(16'hFFFF));
    c.list_index = IDX_W'($urandom_range(12'hFFF));
    roll = $urandom_range(99);
    if (roll < clear_pct) begin
      c.action = ACT_CLEAR;
    end else if (roll < 70) begin
      c.action  = ACT_HIT;
      c.edge_id = ID_W'(pick_id(top_id, pool, hot_pct));
    end else if (roll < 85) begin
      c.action  = ACT_READ_CNT;
      c.edge_id = ID_W'(pick_id(top_id, pool, hot_pct));
    end else begin
      c.action = ACT_READ_LIST;
      if ($urandom_range(3) != 0) c.list_index = IDX_W'($urandom_range(0, 40));
    end
    return c;
  endfunction

  task automatic run_phase(input int unsigned lim, input int unsigned pool,
                           input int unsigned hot_pct, input int unsigned clear_pct,
                           input int unsigned n, input bit no_gaps);
    set_limit(lim);
    quiet = no_gaps;
    repeat (n) issue(random_cmd(lim, pool, hot_pct, clear_pct));
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at the reset limit
    issue(make_cmd(ACT_READ_CNT, 0, 0));
    issue(make_cmd(ACT_HIT, 0, 0));
    issue(make_cmd(ACT_HIT, 4095, 0));
    issue(make_cmd(ACT_HIT, 4095, 0));
    issue(make_cmd(ACT_HIT, 1, 0));
    issue(make_cmd(ACT_HIT, 4096, 0));
    issue(make_cmd(ACT_HIT, 16'hFFFF, 0));
    issue(make_cmd(ACT_READ_CNT, 4095, 0));
    issue(make_cmd(ACT_READ_CNT, 1, 0));
    issue(make_cmd(ACT_READ_CNT, 16'hFFFF, 0));
    issue(make_cmd(ACT_READ_LIST, 0, 0));
    issue(make_cmd(ACT_READ_LIST, 0, 1));
    issue(make_cmd(ACT_READ_LIST, 0, 2));
    issue(make_cmd(ACT_READ_LIST, 0, 12'hFFF));
    issue(make_cmd(ACT_CLEAR, 16'hFFFF, 12'hFFF));
    issue(make_cmd(ACT_READ_CNT, 4095, 0));
    issue(make_cmd(ACT_READ_LIST, 0, 0));
    // zero limit rejects every id
    set_limit(0);
    issue(make_cmd(ACT_HIT, 1, 0));
    issue(make_cmd(ACT_READ_CNT, 1, 0));
    // lowered limit keeps listed edges until the next clear
    set_limit(5);
    issue(make_cmd(ACT_HIT, 5, 0));
    issue(make_cmd(ACT_HIT, 6, 0));
    issue(make_cmd(ACT_HIT, 3, 0));
    set_limit(2);
    issue(make_cmd(ACT_READ_CNT, 5, 0));
    issue(make_cmd(ACT_HIT, 5, 0));
    issue(make_cmd(ACT_CLEAR, 0, 0));
    set_limit(4095);
    issue(make_cmd(ACT_READ_CNT, 5, 0));

    run_phase(4095, 0, 5, 3, 300, 1'b0);
    run_phase(17, 17, 75, 0, 300, 1'b1);
    run_phase(0, 0, 0, 3, 100, 1'b0);
    run_phase(4095, 40, 10, 4, 300, 1'b0);
    run_phase(1, 1, 50, 2, 150, 1'b0);
    run_phase(300, 300, 5, 4, 350, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("run: %0d commands under %0d limit settings, %0d results checked",
             commands_sent, limit_writes, checked);
    $display("run: %0d results at the saturated count", saturated);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
